// ===== rtl/aabb_pkg.sv =====
// Package for the bounding box transform unit.
// Holds register indexes, reset values and shared types; no dependencies.
package aabb_pkg;

  localparam int unsigned Axes = 3;
  localparam int unsigned QShift = 16;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5
  } reg_idx_e;

  localparam logic [63:0] RstRow0C01 = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RstRow0C23 = 64'h0;
  localparam logic [63:0] RstRow1C01 = 64'h0001_0000_0000_0000;
  localparam logic [63:0] RstRow1C23 = 64'h0;
  localparam logic [63:0] RstRow2C01 = 64'h0;
  localparam logic [63:0] RstRow2C23 = 64'h0000_0000_0001_0000;

  // One matrix row: three linear coefficients and a translation.
  typedef struct packed {
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] t;
  } row_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } span_t;

endpackage

// ===== rtl/aabb_affine_transform_unit.sv =====
// Top level of the bounding box transform unit: APB registers, pipeline
// control and three axis datapaths. Depends on aabb_pkg and aabb_axis.
//
// Usage: write the three matrix rows over APB (six 64-bit registers at
// byte addresses 8*i, pready always high). Send boxes on the input channel
// (in_valid_i/in_ready_o); the enclosing box of the transformed corners
// comes out on the output channel (out_valid_o/out_ready_i).
// Four register stages: multiply, per-term min/max, wide sum, saturate.
// The first captures at the input transfer edge, and out_valid_o rises once
// the box is held in the saturate stage. Throughput is one box per cycle.
// When the receiver stalls, the whole pipeline holds; in_ready_o follows
// out_ready_i or an empty output stage, so no item is lost or repeated.
// Reset empties the pipeline and loads the identity matrix. Each corner
// coordinate picks lo or hi per axis, so the corner extremes are the sums
// of the per-term extremes.
module aabb_affine_transform_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_min_x_o,
  output logic signed [31:0] out_min_y_o,
  output logic signed [31:0] out_min_z_o,
  output logic signed [31:0] out_max_x_o,
  output logic signed [31:0] out_max_y_o,
  output logic signed [31:0] out_max_z_o
);

  logic [63:0] regs_q [6];
  logic [2:0]  widx;
  logic [3:0]  vld_q;
  logic        en;
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  aabb_pkg::row_t  rows [3];
  aabb_pkg::span_t spans [3];

  assign pready = 1'b1;
  assign widx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[aabb_pkg::REG_ROW0_C01] <= aabb_pkg::RstRow0C01;
      regs_q[aabb_pkg::REG_ROW0_C23] <= aabb_pkg::RstRow0C23;
      regs_q[aabb_pkg::REG_ROW1_C01] <= aabb_pkg::RstRow1C01;
      regs_q[aabb_pkg::REG_ROW1_C23] <= aabb_pkg::RstRow1C23;
      regs_q[aabb_pkg::REG_ROW2_C01] <= aabb_pkg::RstRow2C01;
      regs_q[aabb_pkg::REG_ROW2_C23] <= aabb_pkg::RstRow2C23;
    end else if (psel && penable && pwrite && (widx <= aabb_pkg::REG_ROW2_C23)) begin
      regs_q[widx] <= pwdata;
    end
  end

  always_comb begin
    prdata = 64'h0;
    if (widx <= aabb_pkg::REG_ROW2_C23) begin
      prdata = regs_q[widx];
    end
  end

  // Advance whenever the output stage is empty or being taken.
  assign en = !vld_q[3] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  assign lo[0] = box_min_x_i;
  assign lo[1] = box_min_y_i;
  assign lo[2] = box_min_z_i;
  assign hi[0] = box_max_x_i;
  assign hi[1] = box_max_y_i;
  assign hi[2] = box_max_z_i;

  for (genvar r = 0; r < 3; r++) begin : g_axis
    assign rows[r] = '{m0: regs_q[2*r][31:0], m1: regs_q[2*r][63:32],
                       m2: regs_q[2*r+1][31:0], t: regs_q[2*r+1][63:32]};
    aabb_axis u_axis (
      .clk_i  (clk_i),
      .en_i   (en),
      .row_i  (rows[r]),
      .lo_i   (lo),
      .hi_i   (hi),
      .span_o (spans[r])
    );
  end

  assign out_valid_o = vld_q[3];
  assign out_min_x_o = spans[0].lo;
  assign out_min_y_o = spans[1].lo;
  assign out_min_z_o = spans[2].lo;
  assign out_max_x_o = spans[0].hi;
  assign out_max_y_o = spans[1].hi;
  assign out_max_z_o = spans[2].hi;

endmodule

// ===== rtl/aabb_axis.sv =====
// One output axis of the transform: products, sums, saturation, min/max.
// Depends on aabb_pkg. Four register stages, stall driven by en_i.
module aabb_axis (
  input  logic                clk_i,
  input  logic                en_i,
  input  aabb_pkg::row_t      row_i,
  input  logic signed [31:0]  lo_i [3],
  input  logic signed [31:0]  hi_i [3],
  output aabb_pkg::span_t     span_o
);

  // Stage 1: six products, floor-shifted (arithmetic shift is floor).
  logic signed [47:0] plo_q [3];
  logic signed [47:0] phi_q [3];
  logic signed [31:0] t1_q;
  // Stage 2: per input axis the smaller and larger term, corner sums need
  // only the extremes since each coordinate picks lo or hi independently.
  logic signed [47:0] tmin_q [3];
  logic signed [47:0] tmax_q [3];
  logic signed [31:0] t2_q;
  // Stage 3: wide sums.
  logic signed [50:0] smin_q, smax_q;
  logic signed [31:0] omin_q, omax_q;

  logic signed [63:0] prod_lo [3];
  logic signed [63:0] prod_hi [3];
  logic signed [31:0] coef [3];

  assign coef[0] = row_i.m0;
  assign coef[1] = row_i.m1;
  assign coef[2] = row_i.m2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_lo[j] = coef[j] * lo_i[j];
      prod_hi[j] = coef[j] * hi_i[j];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < -51'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= prod_lo[j][63:16];
        phi_q[j] <= prod_hi[j][63:16];
        tmin_q[j] <= (plo_q[j] < phi_q[j]) ? plo_q[j] : phi_q[j];
        tmax_q[j] <= (plo_q[j] < phi_q[j]) ? phi_q[j] : plo_q[j];
      end
      t1_q <= row_i.t;
      t2_q <= t1_q;
      smin_q <= 51'(tmin_q[0]) + 51'(tmin_q[1]) + 51'(tmin_q[2]) + 51'(t2_q);
      smax_q <= 51'(tmax_q[0]) + 51'(tmax_q[1]) + 51'(tmax_q[2]) + 51'(t2_q);
      omin_q <= sat32(smin_q);
      omax_q <= sat32(smax_q);
    end
  end

  assign span_o.lo = omin_q;
  assign span_o.hi = omax_q;

endmodule

// ===== test/aabb_affine_transform_checker.sv =====
// Checker for the bounding box transform unit: watches the APB port and both
// streaming channels, predicts each enclosing box and compares field by field.
// Depends on aabb_pkg.
module aabb_affine_transform_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_min_x_i,
  input  logic signed [31:0] out_min_y_i,
  input  logic signed [31:0] out_min_z_i,
  input  logic signed [31:0] out_max_x_i,
  input  logic signed [31:0] out_max_y_i,
  input  logic signed [31:0] out_max_z_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output int unsigned        boxes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  logic [63:0] matrix_regs [6];
  box_t        expected_boxes [$];

  function automatic logic signed [31:0] map_coord(logic [63:0] c01, logic [63:0] c23,
                                                   logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
    logic signed [63:0] sum;
    sum = 64'(signed'(c23[63:32]));
    sum += (64'(signed'(c01[31:0])) * 64'(x)) >>> aabb_pkg::QShift;
    sum += (64'(signed'(c01[63:32])) * 64'(y)) >>> aabb_pkg::QShift;
    sum += (64'(signed'(c23[31:0])) * 64'(z)) >>> aabb_pkg::QShift;
    if (sum > 64'sd2147483647) return 32'h7fff_ffff;
    if (sum < -64'sd2147483648) return 32'h8000_0000;
    return sum[31:0];
  endfunction

  function automatic box_t enclose_transformed(box_t b);
    box_t r;
    logic signed [31:0] x, y, z, v [3];
    for (int k = 0; k < 8; k++) begin
      x = k[0] ? b.max_x : b.min_x;
      y = k[1] ? b.max_y : b.min_y;
      z = k[2] ? b.max_z : b.min_z;
      for (int a = 0; a < 3; a++)
        v[a] = map_coord(matrix_regs[2*a], matrix_regs[2*a+1], x, y, z);
      if (k == 0 || v[0] < r.min_x) r.min_x = v[0];
      if (k == 0 || v[1] < r.min_y) r.min_y = v[1];
      if (k == 0 || v[2] < r.min_z) r.min_z = v[2];
      if (k == 0 || v[0] > r.max_x) r.max_x = v[0];
      if (k == 0 || v[1] > r.max_y) r.max_y = v[1];
      if (k == 0 || v[2] > r.max_z) r.max_z = v[2];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors_o++;
    $display("%0t mismatch %s", $realtime, msg);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h want %h", what, got, want));
  endtask

  initial begin
    errors_o = 0;
    boxes_o = 0;
    matrix_regs = '{aabb_pkg::RstRow0C01, aabb_pkg::RstRow0C23,
                    aabb_pkg::RstRow1C01, aabb_pkg::RstRow1C23,
                    aabb_pkg::RstRow2C01, aabb_pkg::RstRow2C23};
  end

  assign pending_o = expected_boxes.size();

  always @(posedge clk_i) begin
    box_t got, want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr[5:3] <= aabb_pkg::REG_ROW2_C23)
        matrix_regs[paddr[5:3]] <= pwdata;
      if (in_valid_i && in_ready_i)
        expected_boxes.insert(expected_boxes.size(),
          enclose_transformed({box_min_x_i, box_min_y_i, box_min_z_i,
                               box_max_x_i, box_max_y_i, box_max_z_i}));
      if (out_valid_i && out_ready_i) begin
        got = {out_min_x_i, out_min_y_i, out_min_z_i, out_max_x_i, out_max_y_i, out_max_z_i};
        boxes_o++;
        if (expected_boxes.size() == 0) begin
          report_mismatch("result transfer with no box outstanding");
        end else begin
          want = expected_boxes.pop_front();
          check_field("min_x", got.min_x, want.min_x);
          check_field("min_y", got.min_y, want.min_y);
          check_field("min_z", got.min_z, want.min_z);
          check_field("max_x", got.max_x, want.max_x);
          check_field("max_y", got.max_y, want.max_y);
          check_field("max_z", got.max_z, want.max_z);
        end
      end
    end
  end
endmodule

// ===== test/aabb_affine_transform_unit_tb.sv =====
// Testbench top for the bounding box transform unit: drives APB matrix writes
// and boxes with random idling, and gives the verdict.
// Depends on aabb_pkg, aabb_affine_transform_unit and aabb_affine_transform_checker.
module aabb_affine_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o, out_valid_o, out_ready_i = 1'b0;
  logic signed [31:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [31:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic signed [31:0] out_min_x_o, out_min_y_o, out_min_z_o;
  logic signed [31:0] out_max_x_o, out_max_y_o, out_max_z_o;
  int unsigned errors, pending, boxes;
  int unsigned sent = 0;
  bit calm = 1'b0;

  aabb_affine_transform_unit dut (.*);

  aabb_affine_transform_checker checker_inst (
    .in_ready_i(in_ready_o), .out_valid_i(out_valid_o),
    .out_min_x_i(out_min_x_o), .out_min_y_i(out_min_y_o), .out_min_z_i(out_min_z_o),
    .out_max_x_i(out_max_x_o), .out_max_y_i(out_max_y_o), .out_max_z_i(out_max_z_o),
    .errors_o(errors), .pending_o(pending), .boxes_o(boxes), .*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stalls about 14 percent of cycles, except in the calm stretch.
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 14);

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2, 3: return 32'($signed($urandom_range(20'hfffff))) - 32'h8_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(18'h3ffff))) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(aabb_pkg::reg_idx_e idx, logic [63:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high between back-to-back boxes; drop it only on an idle.
  task automatic send_box(logic [31:0] a, b, c, d, e, f);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {box_min_x_i, box_min_y_i, box_min_z_i} <= {a, b, c};
    {box_max_x_i, box_max_y_i, box_max_z_i} <= {d, e, f};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_matrix(int mode);
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: write_reg(aabb_pkg::reg_idx_e'(i), '1);
        1: write_reg(aabb_pkg::reg_idx_e'(i), 64'h8000_0000_8000_0000);
        2: write_reg(aabb_pkg::reg_idx_e'(i), 64'h7fff_ffff_7fff_ffff);
        3: write_reg(aabb_pkg::reg_idx_e'(i), {rand_coef(), rand_coef()});
        default: write_reg(aabb_pkg::reg_idx_e'(i), 64'h0);
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Identity matrix: extremes, zero box, and min above max.
    send_box(0, 0, 0, 0, 0, 0);
    send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_box(32'hffff_0000, 32'hfffe_0000, 32'hfffd_0000,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'hffff_0000, 32'hfffe_0000, 32'hfffd_0000);
    send_box('1, 32'h5555_5555, 32'haaaa_aaaa, 32'h1, 32'haaaa_aaaa, 32'h5555_5555);
    drain();
    for (int mode = 0; mode < 5; mode++) begin
      load_matrix(mode);
      for (int i = 0; i < 4; i++)
        send_box(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    for (int phase = 0; phase < 6; phase++) begin
      load_matrix(phase == 4 ? 0 : 3);
      if (phase == 5) write_reg(aabb_pkg::REG_ROW0_C01, 64'h0001_0000);
      calm = (phase == 2);
      for (int i = 0; i < 300; i++)
        send_box(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      calm = 1'b0;
      drain();
    end
    $display("Sent %0d boxes over several matrix settings; %0d results checked.",
             sent, boxes);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
